### hw/rtl/sample_store_range_stats_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sample store range statistics block
// Every macro samples on clk and is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_STORE_RANGE_STATS_ASSERT_SVH
`define SAMPLE_STORE_RANGE_STATS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SSRS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssrs assertion failed");

// Consequent must hold in the cycle after the antecedent
`define SSRS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssrs assertion failed");

`endif

### hw/rtl/ssrs_pkg.sv
// ----------------------------------------------------------------------------
// ssrs_pkg
// Shared constants, codes and inter-module structs of the sample store.
// ----------------------------------------------------------------------------
package ssrs_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int SAMPLE_BITS = 16;
	localparam int RANGE_BITS  = 16;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	// sum of a full store of signed samples
	localparam int SUM_W       = SAMPLE_BITS + IDX_W + 1;
	localparam int MAG_W       = SUM_W - 1;
	localparam int DIV_STEP_W  = $clog2(MAG_W);

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_QUERY  = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NOP    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_RANGE = 2'd1,
		STAT_NO_DATA   = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic                          en;
		logic [IDX_W-1:0]              addr;
		logic signed [SAMPLE_BITS-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] dividend;
		logic [CNT_W-1:0]        divisor;
	} div_req_t;

	typedef struct packed {
		logic                          done;
		logic signed [SAMPLE_BITS-1:0] quotient;
	} div_res_t;

endpackage

### hw/rtl/sample_store_range_stats.sv
// ----------------------------------------------------------------------------
// sample_store_range_stats
// Store of signed Q8.8 samples with append, clear and range min/max/mean query.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one word per action. s_tuser holds the action code
//   (append, query, clear, no-op); s_tdata holds sample, range low, range high.
//   Output channel m_*: exactly one result word per input word, in order.
//   m_tuser holds the status; m_tdata holds mean, min, max and count.
//   The block works on one word at a time: s_tready is high only when idle.
//   Append, clear and no-op pass from accept through ST_RESP to the output
//   register. A query over n stored samples first scans them: the scan reads
//   one memory entry per cycle through the single read port, then the serial
//   divider forms the mean, one quotient bit per cycle, before ST_RESP.
//   Failed queries (bad range, no data) and full appends go straight from
//   accept to ST_RESP. Reset empties the store (fill count zero); memory
//   contents are not cleared and no sweep is needed. If the receiver stalls,
//   the result waits in the output register; the next word may be accepted
//   meanwhile, but its result is held until the output register frees up.
// ----------------------------------------------------------------------------
`include "sample_store_range_stats_assert.svh"

module sample_store_range_stats (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // sample_value[15:0], range_low[31:16], range_high[47:32]
	input  logic [1:0]  s_tuser,  // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // mean[15:0], min[31:16], max[47:32], count[58:48], zero
	output logic [1:0]  m_tuser   // status[1:0]
);

	localparam logic [ssrs_pkg::CNT_W-1:0] DEPTH_C = ssrs_pkg::CNT_W'(ssrs_pkg::STORE_DEPTH);

	ssrs_pkg::state_t  state_q, state_nx;
	ssrs_pkg::action_t act;
	ssrs_pkg::mem_wr_t mem_wr;
	ssrs_pkg::div_req_t div_req;
	ssrs_pkg::div_res_t div_res;

	logic                                    accept;
	logic signed [ssrs_pkg::SAMPLE_BITS-1:0] in_sample;
	logic [ssrs_pkg::RANGE_BITS-1:0]         in_lo;
	logic [ssrs_pkg::RANGE_BITS-1:0]         in_hi;
	logic [ssrs_pkg::RANGE_BITS-1:0]         fill_ext;
	logic                                    bad_range;
	logic                                    no_data;
	logic                                    store_full;
	logic [ssrs_pkg::CNT_W-1:0]              last_idx;
	logic [ssrs_pkg::IDX_W-1:0]              hi_clamp;
	logic [ssrs_pkg::CNT_W-1:0]              cnt_start;
	logic                                    rd_en;
	logic                                    div_start;
	logic signed [ssrs_pkg::SAMPLE_BITS-1:0] rd_data;
	logic                                    out_free;

	// control registers
	logic [ssrs_pkg::CNT_W-1:0] fill_q;
	logic                       rd_vld_s1;
	logic                       first_q;
	logic                       m_tvalid_q;

	// payload registers
	logic [ssrs_pkg::IDX_W-1:0]              idx_q;
	logic [ssrs_pkg::IDX_W-1:0]              end_q;
	logic [ssrs_pkg::CNT_W-1:0]              cnt_q;
	logic signed [ssrs_pkg::SAMPLE_BITS-1:0] min_q;
	logic signed [ssrs_pkg::SAMPLE_BITS-1:0] max_q;
	logic signed [ssrs_pkg::SUM_W-1:0]       sum_q;
	ssrs_pkg::status_t                       res_status_q;
	logic signed [ssrs_pkg::SAMPLE_BITS-1:0] res_mean_q;
	logic signed [ssrs_pkg::SAMPLE_BITS-1:0] res_min_q;
	logic signed [ssrs_pkg::SAMPLE_BITS-1:0] res_max_q;
	logic [ssrs_pkg::CNT_W-1:0]              res_cnt_q;
	ssrs_pkg::status_t                       out_status_q;
	logic signed [ssrs_pkg::SAMPLE_BITS-1:0] out_mean_q;
	logic signed [ssrs_pkg::SAMPLE_BITS-1:0] out_min_q;
	logic signed [ssrs_pkg::SAMPLE_BITS-1:0] out_max_q;
	logic [ssrs_pkg::CNT_W-1:0]              out_cnt_q;

	// unpack input word
	assign act       = ssrs_pkg::action_t'(s_tuser);
	assign in_sample = s_tdata[15:0];
	assign in_lo     = s_tdata[31:16];
	assign in_hi     = s_tdata[47:32];
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;

	// query range checks and clamp
	assign fill_ext   = {{(ssrs_pkg::RANGE_BITS - ssrs_pkg::CNT_W){1'b0}}, fill_q};
	assign bad_range  = in_lo > in_hi;
	assign no_data    = in_lo >= fill_ext;
	assign store_full = fill_q == DEPTH_C;
	assign last_idx   = fill_q - 1'b1;
	assign hi_clamp   = (in_hi >= fill_ext) ? last_idx[ssrs_pkg::IDX_W-1:0]
	                                        : in_hi[ssrs_pkg::IDX_W-1:0];
	assign cnt_start  = {1'b0, hi_clamp} - {1'b0, in_lo[ssrs_pkg::IDX_W-1:0]} + 1'b1;

	// store write on append
	assign mem_wr.en   = accept && (act == ssrs_pkg::ACT_APPEND) && !store_full;
	assign mem_wr.addr = fill_q[ssrs_pkg::IDX_W-1:0];
	assign mem_wr.data = in_sample;

	assign div_req.start    = div_start;
	assign div_req.dividend = sum_q;
	assign div_req.divisor  = cnt_q;

	ssrs_store u_store (
		.clk     (clk),
		.wr      (mem_wr),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	ssrs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ssrs_pkg::ST_IDLE: begin
				if (accept) begin
					if (act == ssrs_pkg::ACT_QUERY && !bad_range && !no_data) begin
						state_nx = ssrs_pkg::ST_SCAN;
					end else begin
						state_nx = ssrs_pkg::ST_RESP;
					end
				end
			end
			ssrs_pkg::ST_SCAN: begin
				if (idx_q == end_q) begin
					state_nx = ssrs_pkg::ST_DRAIN;
				end
			end
			ssrs_pkg::ST_DRAIN:   state_nx = ssrs_pkg::ST_DIV_GO;
			ssrs_pkg::ST_DIV_GO:  state_nx = ssrs_pkg::ST_DIV_WAIT;
			ssrs_pkg::ST_DIV_WAIT: begin
				if (div_res.done) begin
					state_nx = ssrs_pkg::ST_RESP;
				end
			end
			ssrs_pkg::ST_RESP: begin
				if (out_free) begin
					state_nx = ssrs_pkg::ST_IDLE;
				end
			end
			default: state_nx = ssrs_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready  = 1'b0;
		rd_en     = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ssrs_pkg::ST_IDLE:   s_tready  = 1'b1;
			ssrs_pkg::ST_SCAN:   rd_en     = 1'b1;
			ssrs_pkg::ST_DIV_GO: div_start = 1'b1;
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ssrs_pkg::ST_IDLE;
			fill_q     <= '0;
			rd_vld_s1  <= 1'b0;
			first_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q   <= state_nx;
			rd_vld_s1 <= rd_en;
			if (mem_wr.en) begin
				fill_q <= fill_q + 1'b1;
			end else if (accept && act == ssrs_pkg::ACT_CLEAR) begin
				fill_q <= '0;
			end
			if (accept) begin
				first_q <= 1'b1;
			end else if (rd_vld_s1) begin
				first_q <= 1'b0;
			end
			if (state_q == ssrs_pkg::ST_RESP && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath: item decode, scan accumulate, result staging, output register
	always_ff @(posedge clk) begin
		if (accept) begin
			res_mean_q <= '0;
			res_min_q  <= '0;
			res_max_q  <= '0;
			res_cnt_q  <= '0;
			idx_q      <= in_lo[ssrs_pkg::IDX_W-1:0];
			end_q      <= hi_clamp;
			cnt_q      <= cnt_start;
			sum_q      <= '0;
			priority if (act == ssrs_pkg::ACT_APPEND && store_full) begin
				res_status_q <= ssrs_pkg::STAT_FULL;
			end else if (act == ssrs_pkg::ACT_QUERY && bad_range) begin
				res_status_q <= ssrs_pkg::STAT_BAD_RANGE;
			end else if (act == ssrs_pkg::ACT_QUERY && no_data) begin
				res_status_q <= ssrs_pkg::STAT_NO_DATA;
			end else begin
				res_status_q <= ssrs_pkg::STAT_OK;
			end
		end
		if (rd_en) begin
			idx_q <= idx_q + 1'b1;
		end
		// compare and add on each returning sample
		if (rd_vld_s1) begin
			sum_q <= sum_q + {{(ssrs_pkg::SUM_W - ssrs_pkg::SAMPLE_BITS){rd_data[ssrs_pkg::SAMPLE_BITS-1]}},
			                  rd_data};
			if (first_q || rd_data < min_q) begin
				min_q <= rd_data;
			end
			if (first_q || rd_data > max_q) begin
				max_q <= rd_data;
			end
		end
		if (state_q == ssrs_pkg::ST_DIV_WAIT && div_res.done) begin
			res_mean_q <= div_res.quotient;
			res_min_q  <= min_q;
			res_max_q  <= max_q;
			res_cnt_q  <= cnt_q;
		end
		if (state_q == ssrs_pkg::ST_RESP && out_free) begin
			out_status_q <= res_status_q;
			out_mean_q   <= res_mean_q;
			out_min_q    <= res_min_q;
			out_max_q    <= res_max_q;
			out_cnt_q    <= res_cnt_q;
		end
	end

	// pack output word
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {5'b0, out_cnt_q, out_max_q, out_min_q, out_mean_q};

	// checks
	`SSRS_ASSERT_SAME(a_rd_below_fill, rd_en, {1'b0, idx_q} < fill_q)
	`SSRS_ASSERT_SAME(a_div_done_wait, div_res.done, state_q == ssrs_pkg::ST_DIV_WAIT)
	`SSRS_ASSERT_NEXT(a_append_fill, mem_wr.en, fill_q == $past(fill_q) + 1'b1)

endmodule

### hw/rtl/ssrs_store.sv
// ----------------------------------------------------------------------------
// ssrs_store
// Sample memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ssrs_store (
	input  logic                                    clk,
	input  ssrs_pkg::mem_wr_t                       wr,
	input  logic                                    rd_en,
	input  logic [ssrs_pkg::IDX_W-1:0]              rd_addr,
	output logic signed [ssrs_pkg::SAMPLE_BITS-1:0] rd_data
);

	logic signed [ssrs_pkg::SAMPLE_BITS-1:0] mem_q [ssrs_pkg::STORE_DEPTH];
	logic signed [ssrs_pkg::SAMPLE_BITS-1:0] rd_data_q;

	// write and read, read data is registered and lands in the cycle after the read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/ssrs_div.sv
// ----------------------------------------------------------------------------
// ssrs_div
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module ssrs_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ssrs_pkg::div_req_t req,
	output ssrs_pkg::div_res_t res
);

	localparam logic [ssrs_pkg::DIV_STEP_W-1:0] LAST_STEP =
		ssrs_pkg::DIV_STEP_W'(ssrs_pkg::MAG_W - 1);

	logic                               busy_q;
	logic                               done_q;
	logic [ssrs_pkg::DIV_STEP_W-1:0]    step_q;
	logic                               neg_q;
	logic [ssrs_pkg::CNT_W-1:0]         divisor_q;
	logic [ssrs_pkg::CNT_W-1:0]         rem_q;
	logic [ssrs_pkg::MAG_W-1:0]         quo_q;

	logic [ssrs_pkg::SUM_W-1:0]         mag_full;
	logic [ssrs_pkg::CNT_W:0]           rem_sh;
	logic [ssrs_pkg::CNT_W:0]           rem_sub;
	logic                               fits;
	logic [ssrs_pkg::SAMPLE_BITS-1:0]   quo_lo;

	// magnitude of the dividend at start
	assign mag_full = req.dividend[ssrs_pkg::SUM_W-1] ? -req.dividend : req.dividend;

	// one restoring step: shift in next dividend bit, try subtract
	assign rem_sh  = {rem_q, quo_q[ssrs_pkg::MAG_W-1]};
	assign fits    = rem_sh >= {1'b0, divisor_q};
	assign rem_sub = rem_sh - {1'b0, divisor_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q     <= req.dividend[ssrs_pkg::SUM_W-1];
			divisor_q <= req.divisor;
			rem_q     <= '0;
			quo_q     <= mag_full[ssrs_pkg::MAG_W-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[ssrs_pkg::CNT_W-1:0] : rem_sh[ssrs_pkg::CNT_W-1:0];
			quo_q <= {quo_q[ssrs_pkg::MAG_W-2:0], fits};
		end
	end

	// restore sign on the low bits only, the mean always fits a sample
	assign quo_lo       = quo_q[ssrs_pkg::SAMPLE_BITS-1:0];
	assign res.done     = done_q;
	assign res.quotient = neg_q ? -quo_lo : quo_lo;

endmodule
